FILE: hw/rtl/rsg_pkg.sv
// ----------------------------------------------------------------------------
// rsg_pkg
// Shared types and codes for the run stability gate.
// ----------------------------------------------------------------------------
package rsg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 3;
  localparam int unsigned WordW = 64;

  typedef enum logic [1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_ARM     = 2'd1,
    CMD_CANCEL  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OBS_NONE      = 2'd0,
    OBS_CANCELLED = 2'd1,
    OBS_RESET     = 2'd2,
    OBS_READY     = 2'd3
  } obs_e;

  typedef enum logic [0:0] {
    REG_REQUIRED_RUN_TIME = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [WordW-1:0] link_generation;
    logic             renderer_on;
    logic [WordW-1:0] renderer_tag;
    logic [WordW-1:0] now_time;
  } item_t;

endpackage

FILE: hw/rtl/rsg_apb_regs.sv
// ----------------------------------------------------------------------------
// rsg_apb_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module rsg_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsg_pkg::AddrW-1:0]  paddr,
  input  logic [rsg_pkg::DataW-1:0]  pwdata,
  output logic [rsg_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output logic [rsg_pkg::DataW-1:0]  required_run_time_o
);

  logic [rsg_pkg::DataW-1:0] run_time_q;
  logic                      hit;

  assign hit    = (paddr[2] == rsg_pkg::REG_REQUIRED_RUN_TIME);
  assign pready = 1'b1;
  assign prdata = hit ? run_time_q : '0;
  assign required_run_time_o = run_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_time_q <= '0;
    end else if (psel && penable && pwrite && hit) begin
      run_time_q <= pwdata;
    end
  end

endmodule

FILE: hw/rtl/rsg_gate.sv
// ----------------------------------------------------------------------------
// rsg_gate
// Gate state and the decision logic applied to one registered transaction.
// ----------------------------------------------------------------------------
module rsg_gate (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  rsg_pkg::item_t             item_i,
  input  logic [rsg_pkg::DataW-1:0]  required_run_time_i,
  output rsg_pkg::obs_e              obs_o
);

  logic                      pending_q, pending_d;
  logic                      observing_q, observing_d;
  logic [rsg_pkg::WordW-1:0] armed_gen_q, armed_gen_d;
  logic [rsg_pkg::WordW-1:0] epoch_q, epoch_d;
  logic [rsg_pkg::WordW-1:0] since_q, since_d;
  logic [rsg_pkg::WordW-1:0] elapsed;
  logic                      short_run;
  rsg_pkg::obs_e             obs;

  assign elapsed   = item_i.now_time - since_q;
  assign short_run = elapsed < {{(rsg_pkg::WordW-rsg_pkg::DataW){1'b0}}, required_run_time_i};

  always_comb begin
    pending_d   = pending_q;
    observing_d = observing_q;
    armed_gen_d = armed_gen_q;
    epoch_d     = epoch_q;
    since_d     = since_q;
    obs         = rsg_pkg::OBS_NONE;
    case (rsg_pkg::cmd_e'(item_i.command))
      rsg_pkg::CMD_OBSERVE: begin
        if (pending_q) begin
          if (item_i.link_generation != armed_gen_q) begin
            pending_d   = 1'b0;
            observing_d = 1'b0;
            armed_gen_d = '0;
            epoch_d     = '0;
            since_d     = '0;
            obs         = rsg_pkg::OBS_CANCELLED;
          end else if (!item_i.renderer_on) begin
            if (observing_q) begin
              observing_d = 1'b0;
              epoch_d     = '0;
              since_d     = '0;
              obs         = rsg_pkg::OBS_RESET;
            end
          end else if (!observing_q) begin
            observing_d = 1'b1;
            epoch_d     = item_i.renderer_tag;
            since_d     = item_i.now_time;
          end else if ((item_i.renderer_tag != epoch_q) || (item_i.now_time < since_q)) begin
            epoch_d = item_i.renderer_tag;
            since_d = item_i.now_time;
            obs     = rsg_pkg::OBS_RESET;
          end else if (!short_run) begin
            pending_d   = 1'b0;
            observing_d = 1'b0;
            obs         = rsg_pkg::OBS_READY;
          end
        end
      end
      rsg_pkg::CMD_ARM: begin
        pending_d   = 1'b1;
        armed_gen_d = item_i.link_generation;
        observing_d = item_i.renderer_on;
        epoch_d     = item_i.renderer_on ? item_i.renderer_tag : '0;
        since_d     = item_i.renderer_on ? item_i.now_time : '0;
      end
      rsg_pkg::CMD_CANCEL: begin
        pending_d   = 1'b0;
        observing_d = 1'b0;
        armed_gen_d = '0;
        epoch_d     = '0;
        since_d     = '0;
      end
      default: begin
        obs = rsg_pkg::OBS_NONE;
      end
    endcase
  end

  assign obs_o = obs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      observing_q <= 1'b0;
      armed_gen_q <= '0;
      epoch_q     <= '0;
      since_q     <= '0;
    end else if (fire_i) begin
      pending_q   <= pending_d;
      observing_q <= observing_d;
      armed_gen_q <= armed_gen_d;
      epoch_q     <= epoch_d;
      since_q     <= since_d;
    end
  end

endmodule

FILE: hw/rtl/run_stability_gate_core.sv
// ----------------------------------------------------------------------------
// run_stability_gate_core
// Stability gate that reports when a renderer has run without a break.
//
// Each input transaction carries a command (observe, arm or cancel) with the
// link generation, renderer state, renderer epoch and time in milliseconds.
// Every input transaction yields exactly one output transaction carrying the
// observation code, in order. The input is captured in an input register,
// the gate logic evaluates it against the stored state, and the answer is
// captured in an output register. One transaction is accepted every cycle
// while the output is not stalled. When the receiver stalls, the output
// register holds its transaction and the input register fills; the input
// stall then rises until the output is taken. The user must write the
// required run time through the APB-style port only while the block is
// idle; the block itself does not enforce this. Reset clears the gate state,
// the run time register and the valid flags of both pipeline registers.
// ----------------------------------------------------------------------------
module run_stability_gate_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsg_pkg::AddrW-1:0]  paddr,
  input  logic [rsg_pkg::DataW-1:0]  pwdata,
  output logic [rsg_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [rsg_pkg::WordW-1:0]  link_generation_i,
  input  logic                       renderer_on_i,
  input  logic [rsg_pkg::WordW-1:0]  renderer_tag_i,
  input  logic [rsg_pkg::WordW-1:0]  now_time_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 observation_o
);

  logic [rsg_pkg::DataW-1:0] run_time;
  logic                      in_valid_q;
  rsg_pkg::item_t            item_q;
  logic                      out_valid_q;
  rsg_pkg::obs_e             obs_q;
  rsg_pkg::obs_e             obs;
  logic                      advance;
  logic                      in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  rsg_apb_regs u_regs (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .required_run_time_o (run_time)
  );

  rsg_gate u_gate (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .fire_i              (in_valid_q && advance),
    .item_i              (item_q),
    .required_run_time_i (run_time),
    .obs_o               (obs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command         <= command_i;
      item_q.link_generation <= link_generation_i;
      item_q.renderer_on     <= renderer_on_i;
      item_q.renderer_tag    <= renderer_tag_i;
      item_q.now_time        <= now_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      obs_q <= obs;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign observation_o = obs_q;

endmodule

FILE: hw/rtl/rsg_checker.sv
// ----------------------------------------------------------------------------
// rsg_checker
// Port-level checks on the run stability gate, attached by bind.
// ----------------------------------------------------------------------------
module rsg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] observation_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output transaction dropped while stalled.");

  a_obs_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(observation_o))
    else $error("Observation changed while stalled.");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("Input stalled while the output register is empty.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("Output transaction without an input transaction two cycles earlier.");

endmodule

bind run_stability_gate_core rsg_checker u_rsg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .observation_o (observation_o)
);
